FILE: hdl/tia_pkg.sv
// Shared types, widths and constants for the triangle interior angle pipeline.
// No dependencies; used by tia_div, tia_angle and triangle_interior_angles.
package tia_pkg;

	// coordinate and angle formats
	localparam int COORD_W    = 16;
	localparam int ANGLE_FRAC = 8;
	localparam int ANGLE_W    = 8 + ANGLE_FRAC;

	// datapath widths
	localparam int SQ_W     = 2 * COORD_W + 1;     // squared side
	localparam int LEN_IN_W = SQ_W + 9;            // squared side << 8, padded to even
	localparam int LEN_W    = LEN_IN_W / 2;        // side length, 4 fraction bits
	localparam int NUM_W    = SQ_W + 2;            // signed law of cosines numerator
	localparam int MAG_W    = NUM_W - 1 + 24;      // |numerator| << 24
	localparam int DEN_W    = 2 * LEN_W + 1;       // 2 * len_p * len_q
	localparam int Q_W      = 18;                  // raw quotient, top bit flags overflow
	localparam int X_W      = 17;                  // |cos| in Q16, at most 1.0
	localparam int S_IN_W   = 34;                  // (1 - x) << 16
	localparam int S_W      = S_IN_W / 2;          // sqrt(1 - x) in Q16
	localparam int P_W      = 34;                  // polynomial accumulator, signed
	localparam int R_W      = 32;                  // radians in Q30
	localparam int RD_W     = 30;                  // degrees per radian constant
	localparam int PROD_W   = R_W + RD_W + 1;      // degree product with headroom
	localparam int DEG_SHIFT = 54 - ANGLE_FRAC;

	localparam logic [X_W-1:0]    ONE_Q16     = X_W'(65536);
	localparam logic [R_W-1:0]    PI_Q30      = 32'd3373259426;
	localparam logic [RD_W-1:0]   RAD2DEG_Q24 = 30'd961263669;
	localparam logic [PROD_W-1:0] ROUND_HALF  = PROD_W'(1) << (53 - ANGLE_FRAC);

	// arccosine polynomial, Q30, lowest order first
	localparam logic signed [31:0] ACOS_COEF [8] = '{
		32'sd1686629690, -32'sd230423709, 32'sd95540460, -32'sd53874249,
		32'sd33169905, -32'sd18348235, 32'sd7161955, -32'sd1355590
	};

	typedef struct packed {
		logic [COORD_W-1:0] x_one;
		logic [COORD_W-1:0] y_one;
		logic [COORD_W-1:0] x_two;
		logic [COORD_W-1:0] y_two;
		logic [COORD_W-1:0] x_three;
		logic [COORD_W-1:0] y_three;
	} tri_in_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle_at_three;
		logic [ANGLE_W-1:0] angle_at_one;
		logic [ANGLE_W-1:0] angle_at_two;
		logic               degenerate;
	} tri_out_t;

	function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] u,
	                                                 input logic [COORD_W-1:0] v);
		return (u > v) ? (u - v) : (v - u);
	endfunction

endpackage

FILE: hdl/tia_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband
// that travels alongside. Self-contained; no package needed.
module tia_isqrt #(
	parameter int W  = 42,
	parameter int PW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [W-1:0]   in_val,
	input  logic [PW-1:0]  in_side,
	output logic           out_valid,
	output logic [W/2-1:0] out_root,
	output logic [PW-1:0]  out_side
);
	localparam int N = W / 2;

	logic [W-1:0]  rem_s  [N+1];
	logic [W-1:0]  root_s [N+1];
	logic [PW-1:0] side_s [N+1];
	logic          vld_s  [N+1];

	assign rem_s[0]  = in_val;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_valid;

	// one restoring step per stage
	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [W-1:0] STEP_BIT = W'(1) << (W - 2 - 2 * k);
		logic [W-1:0] trial;
		logic         take;

		assign trial = root_s[k] + STEP_BIT;
		assign take  = rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? (rem_s[k] - trial) : rem_s[k];
				root_s[k+1] <= take ? ((root_s[k] >> 1) + STEP_BIT) : (root_s[k] >> 1);
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_root  = root_s[N][N-1:0];
	assign out_side  = side_s[N];

endmodule

FILE: hdl/tia_div.sv
// Pipelined restoring divider for the cosine ratio, saturating at 1.0 in Q16.
// Depends on tia_pkg for widths.
module tia_div import tia_pkg::*; #(
	parameter int PW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [MAG_W-1:0] in_mag,
	input  logic [DEN_W-1:0] in_den,
	input  logic [PW-1:0]    in_side,
	output logic             out_valid,
	output logic [X_W-1:0]   out_x,
	output logic [PW-1:0]    out_side
);
	localparam int DW = DEN_W + Q_W - 1;

	logic [MAG_W-1:0] rem_s  [Q_W+1];
	logic [DEN_W-1:0] den_s  [Q_W+1];
	logic [Q_W-1:0]   quo_s  [Q_W+1];
	logic [PW-1:0]    side_s [Q_W+1];
	logic             vld_s  [Q_W+1];
	logic [Q_W-1:0]   quo;

	assign rem_s[0]  = in_mag;
	assign den_s[0]  = in_den;
	assign quo_s[0]  = '0;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_valid;

	// one quotient bit per stage, MSB first; the top bit only flags overflow
	for (genvar k = 0; k < Q_W; k++) begin : g_step
		localparam int SH = Q_W - 1 - k;
		logic [DW-1:0] dsh;
		logic          take;

		assign dsh  = DW'(den_s[k]) << SH;
		assign take = DW'(rem_s[k]) >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? (rem_s[k] - dsh[MAG_W-1:0]) : rem_s[k];
				den_s[k+1]  <= den_s[k];
				quo_s[k+1]  <= quo_s[k] | (take ? (Q_W'(1) << SH) : '0);
				side_s[k+1] <= side_s[k];
			end
		end
	end

	// saturate to 1.0
	assign quo       = quo_s[Q_W];
	assign out_x     = (quo[Q_W-1] || (quo[X_W-1:0] > ONE_Q16)) ? ONE_Q16 : quo[X_W-1:0];
	assign out_valid = vld_s[Q_W];
	assign out_side  = side_s[Q_W];

endmodule

FILE: hdl/tia_angle.sv
// One interior angle: cosine division, arccosine polynomial times sqrt(1 - x),
// obtuse fold and conversion to degrees. Depends on tia_pkg, tia_div and tia_isqrt.
module tia_angle import tia_pkg::*; #(
	parameter int PW = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [MAG_W-1:0]   in_mag,
	input  logic [DEN_W-1:0]   in_den,
	input  logic               in_neg,
	input  logic [PW-1:0]      in_side,
	output logic               out_valid,
	output logic [ANGLE_W-1:0] out_angle,
	output logic [PW-1:0]      out_side
);
	localparam int SQ_SIDE_W = PW + 1 + X_W;

	logic                 dv;
	logic [X_W-1:0]       dx;
	logic [PW:0]          dside;
	logic [S_IN_W-1:0]    sq_in;
	logic                 sv;
	logic [S_W-1:0]       sroot;
	logic [SQ_SIDE_W-1:0] sside;

	logic signed [P_W-1:0] p_s    [8];
	logic [X_W-1:0]        x_p_s  [8];
	logic [S_W-1:0]        s_p_s  [8];
	logic                  neg_p_s[8];
	logic [PW-1:0]         side_p_s[8];
	logic                  vld_p_s[8];

	logic [P_W-2:0]        p_pos;
	logic [P_W+S_W-2:0]    pr_prod;
	logic [R_W-1:0]        r_s1, r_s2;
	logic                  neg_s1;
	logic [PW-1:0]         side_s1, side_s2, side_s3;
	logic                  v_s1, v_s2, v_s3;
	logic [PROD_W-1:0]     deg_s3;
	logic [PROD_W-1:0]     deg_rnd;

	// cosine magnitude
	tia_div #(.PW(PW + 1)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_mag    (in_mag),
		.in_den    (in_den),
		.in_side   ({in_neg, in_side}),
		.out_valid (dv),
		.out_x     (dx),
		.out_side  (dside)
	);

	// sqrt(1 - x) in Q16
	assign sq_in = S_IN_W'(ONE_Q16 - dx) << 16;

	tia_isqrt #(.W(S_IN_W), .PW(SQ_SIDE_W)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dv),
		.in_val    (sq_in),
		.in_side   ({dside, dx}),
		.out_valid (sv),
		.out_root  (sroot),
		.out_side  (sside)
	);

	assign p_s[0]      = P_W'(ACOS_COEF[7]);
	assign x_p_s[0]    = sside[X_W-1:0];
	assign s_p_s[0]    = sroot;
	assign side_p_s[0] = sside[X_W +: PW];
	assign neg_p_s[0]  = sside[SQ_SIDE_W-1];
	assign vld_p_s[0]  = sv;

	// Horner steps, product truncated toward zero
	for (genvar k = 0; k < 7; k++) begin : g_horner
		logic signed [P_W+X_W:0] prod;
		logic signed [P_W+X_W:0] trunc;

		assign prod  = p_s[k] * $signed({1'b0, x_p_s[k]});
		assign trunc = (prod + (prod[P_W+X_W] ?
			$signed({{(P_W+X_W-15){1'b0}}, 16'hFFFF}) :
			$signed((P_W+X_W+1)'(0)))) >>> 16;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_p_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_p_s[k+1] <= vld_p_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				p_s[k+1]      <= P_W'(ACOS_COEF[6-k]) + P_W'(trunc);
				x_p_s[k+1]    <= x_p_s[k];
				s_p_s[k+1]    <= s_p_s[k];
				neg_p_s[k+1]  <= neg_p_s[k];
				side_p_s[k+1] <= side_p_s[k];
			end
		end
	end

	// radians = P * s, negative P taken as zero
	assign p_pos   = p_s[7][P_W-1] ? '0 : p_s[7][P_W-2:0];
	assign pr_prod = p_pos * s_p_s[7];
	assign deg_rnd = deg_s3 + ROUND_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= vld_p_s[7];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// radians, obtuse fold, degree product
	always_ff @(posedge clk) begin
		if (en) begin
			r_s1    <= pr_prod[16 +: R_W];
			neg_s1  <= neg_p_s[7];
			side_s1 <= side_p_s[7];
			if (neg_s1) begin
				r_s2 <= (r_s1 > PI_Q30) ? '0 : (PI_Q30 - r_s1);
			end else begin
				r_s2 <= r_s1;
			end
			side_s2 <= side_s1;
			deg_s3  <= PROD_W'(r_s2) * PROD_W'(RAD2DEG_Q24);
			side_s3 <= side_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_angle = deg_rnd[DEG_SHIFT +: ANGLE_W];
	assign out_side  = side_s3;

`ifndef ASSERT_OFF
	a_cos_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		dv |-> (dx <= ONE_Q16))
		else $error("cosine magnitude above 1.0 after division");
`endif

endmodule

FILE: hdl/triangle_interior_angles.sv
// Triangle interior angles. Throughput one triangle per cycle; the pipeline stalls as
// a whole while a result waits. Depth is set by the side-length square roots, the
// 18-step cosine divider and the arccosine square root and polynomial. Asynchronous
// active-low reset clears the valid bits; payload registers are not reset. Depends on
// tia_pkg, tia_isqrt and tia_angle.
module triangle_interior_angles import tia_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  tri_in_t  item,
	output logic     result_valid,
	input  logic     result_ready,
	output tri_out_t result
);
	logic                en;
	logic [COORD_W-1:0]  dx_a_s1, dy_a_s1, dx_b_s1, dy_b_s1, dx_c_s1, dy_c_s1;
	logic [2*COORD_W-1:0] qx_a_s2, qy_a_s2, qx_b_s2, qy_b_s2, qx_c_s2, qy_c_s2;
	logic [SQ_W-1:0]     sa_s3, sb_s3, sc_s3;
	logic                degen_s3;
	logic                v_s1, v_s2, v_s3, v_s4;

	logic                lv;
	logic [LEN_W-1:0]    la, lb, lc;
	logic [3*SQ_W:0]     lside;
	logic [SQ_W-1:0]     sa_l, sb_l, sc_l;

	logic [MAG_W-1:0]    mag_s4 [3];
	logic [DEN_W-1:0]    den_s4 [3];
	logic                neg_s4 [3];
	logic                degen_s4;
	logic [MAG_W:0]      cn [3];

	logic                av;
	logic                adegen;
	logic [ANGLE_W-1:0]  ang [3];

	function automatic logic [MAG_W:0] cos_num(input logic [SQ_W-1:0] opp,
	                                           input logic [SQ_W-1:0] p,
	                                           input logic [SQ_W-1:0] q);
		logic signed [NUM_W-1:0] num;
		logic signed [NUM_W-1:0] absn;
		num  = $signed({2'b00, p}) + $signed({2'b00, q}) - $signed({2'b00, opp});
		absn = num[NUM_W-1] ? -num : num;
		return {num[NUM_W-1], absn[NUM_W-2:0], 24'd0};
	endfunction

	// whole pipeline advances unless a result is held
	assign en         = !result_valid || result_ready;
	assign item_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= lv;
		end
	end

	// coordinate differences, squares, squared sides
	always_ff @(posedge clk) begin
		if (en) begin
			dx_a_s1  <= abs_diff(item.x_one, item.x_two);
			dy_a_s1  <= abs_diff(item.y_one, item.y_two);
			dx_b_s1  <= abs_diff(item.x_two, item.x_three);
			dy_b_s1  <= abs_diff(item.y_two, item.y_three);
			dx_c_s1  <= abs_diff(item.x_three, item.x_one);
			dy_c_s1  <= abs_diff(item.y_three, item.y_one);
			qx_a_s2  <= dx_a_s1 * dx_a_s1;
			qy_a_s2  <= dy_a_s1 * dy_a_s1;
			qx_b_s2  <= dx_b_s1 * dx_b_s1;
			qy_b_s2  <= dy_b_s1 * dy_b_s1;
			qx_c_s2  <= dx_c_s1 * dx_c_s1;
			qy_c_s2  <= dy_c_s1 * dy_c_s1;
			sa_s3    <= SQ_W'(qx_a_s2) + SQ_W'(qy_a_s2);
			sb_s3    <= SQ_W'(qx_b_s2) + SQ_W'(qy_b_s2);
			sc_s3    <= SQ_W'(qx_c_s2) + SQ_W'(qy_c_s2);
			degen_s3 <= ((qx_a_s2 | qy_a_s2) == '0) || ((qx_b_s2 | qy_b_s2) == '0) ||
			            ((qx_c_s2 | qy_c_s2) == '0);
		end
	end

	// side lengths; the first root also carries the squared sides
	tia_isqrt #(.W(LEN_IN_W), .PW(3 * SQ_W + 1)) u_len_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_val    ({1'b0, sa_s3, 8'd0}),
		.in_side   ({degen_s3, sa_s3, sb_s3, sc_s3}),
		.out_valid (lv),
		.out_root  (la),
		.out_side  (lside)
	);

	tia_isqrt #(.W(LEN_IN_W), .PW(1)) u_len_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_val    ({1'b0, sb_s3, 8'd0}),
		.in_side   (1'b0),
		.out_valid (),
		.out_root  (lb),
		.out_side  ()
	);

	tia_isqrt #(.W(LEN_IN_W), .PW(1)) u_len_c (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_val    ({1'b0, sc_s3, 8'd0}),
		.in_side   (1'b0),
		.out_valid (),
		.out_root  (lc),
		.out_side  ()
	);

	assign sa_l = lside[2*SQ_W +: SQ_W];
	assign sb_l = lside[SQ_W +: SQ_W];
	assign sc_l = lside[0 +: SQ_W];

	// law of cosines numerators and denominators
	assign cn[0] = cos_num(sa_l, sb_l, sc_l);
	assign cn[1] = cos_num(sb_l, sc_l, sa_l);
	assign cn[2] = cos_num(sc_l, sa_l, sb_l);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s4[i] <= cn[i][MAG_W-1:0];
				neg_s4[i] <= cn[i][MAG_W];
			end
			den_s4[0] <= (DEN_W'(lb) * DEN_W'(lc)) << 1;
			den_s4[1] <= (DEN_W'(lc) * DEN_W'(la)) << 1;
			den_s4[2] <= (DEN_W'(la) * DEN_W'(lb)) << 1;
			degen_s4  <= lside[3*SQ_W];
		end
	end

	tia_angle #(.PW(1)) u_ang_three (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_mag    (mag_s4[0]),
		.in_den    (den_s4[0]),
		.in_neg    (neg_s4[0]),
		.in_side   (degen_s4),
		.out_valid (av),
		.out_angle (ang[0]),
		.out_side  (adegen)
	);

	tia_angle #(.PW(1)) u_ang_one (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_mag    (mag_s4[1]),
		.in_den    (den_s4[1]),
		.in_neg    (neg_s4[1]),
		.in_side   (1'b0),
		.out_valid (),
		.out_angle (ang[1]),
		.out_side  ()
	);

	tia_angle #(.PW(1)) u_ang_two (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_mag    (mag_s4[2]),
		.in_den    (den_s4[2]),
		.in_neg    (neg_s4[2]),
		.in_side   (1'b0),
		.out_valid (),
		.out_angle (ang[2]),
		.out_side  ()
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (en) begin
			result_valid <= av;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result.degenerate     <= adegen;
			result.angle_at_three <= adegen ? '0 : ang[0];
			result.angle_at_one   <= adegen ? '0 : ang[1];
			result.angle_at_two   <= adegen ? '0 : ang[2];
		end
	end

`ifndef ASSERT_OFF
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.degenerate) |->
		(result.angle_at_three == '0 && result.angle_at_one == '0 &&
		 result.angle_at_two == '0))
		else $error("degenerate transaction with nonzero angle");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (result_valid && !result_ready))
		else $error("input stalled without a held result");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(result)))
		else $error("held result changed before its transaction");
`endif

endmodule
